FILE: sv/q2e_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and the arctangent table for the quaternion to euler bins block
// no dependencies

package q2e_pkg;

	localparam int BIN_COUNT        = 18;
	localparam int QUAT_FRAC_BITS   = 14;
	localparam int ANGLE_ITERATIONS = 16;
	localparam int WORK_FRAC        = 30;

	localparam int QW      = 16;                               // quaternion component width
	localparam int PROD_W  = 2 * QW;                           // one product
	localparam int ACC_W   = PROD_W + 2;                       // sum of two products
	localparam int CW      = 40;                               // cordic vector width
	localparam int ANG_W   = 36;                               // angle, 2^-32 turn units
	localparam int BIN_W   = 5;
	localparam int SS_W    = WORK_FRAC + 1;                    // clamped |s|
	localparam int SQ_W    = 2 * SS_W;                         // sqrt working width
	localparam int SQRT_STEPS = WORK_FRAC + 1;
	localparam int TO_WORK_SHIFT = WORK_FRAC - 2 * QUAT_FRAC_BITS;
	localparam int MUL_STEPS = 9;
	localparam int CNT_W   = 6;
	localparam int UB      = 33;                               // biased angle bits
	localparam int BPROD_W = UB + 6;

	localparam logic [2:0] KIND_ORIENT  = 3'd0;
	localparam logic [2:0] KIND_POSE    = 3'd1;
	localparam logic [2:0] KIND_UNPAIR  = 3'd2;
	localparam logic [2:0] KIND_ARM_ON  = 3'd3;
	localparam logic [2:0] KIND_ARM_OFF = 3'd4;

	localparam logic [2:0] POSE_FIST    = 3'd1;
	localparam logic [2:0] POSE_WAVE_IN = 3'd2;
	localparam logic [2:0] POSE_UNKNOWN = 3'd6;

	localparam logic [1:0] VIB_NONE  = 2'd0;
	localparam logic [1:0] VIB_SHORT = 2'd1;
	localparam logic [1:0] VIB_LONG  = 2'd2;

	localparam logic [1:0] SEL_ROLL  = 2'd0;
	localparam logic [1:0] SEL_YAW   = 2'd1;
	localparam logic [1:0] SEL_PITCH = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_SQMUL,
		ST_SQINIT,
		ST_SQRT,
		ST_CINIT,
		ST_CITER,
		ST_BIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic       load;
		logic       mul_en;
		logic [3:0] mul_idx;
		logic       sq_mul;
		logic       sq_init;
		logic       sq_step;
		logic       c_init;
		logic       c_step;
		logic [4:0] c_idx;
		logic       bin_en;
		logic [1:0] sel;
		logic       commit;
	} cmd_t;

	typedef struct packed {
		logic in_orient;
		logic y_zero;
		logic out_free;
	} sts_t;

	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			5'd24: v = 32'd41;
			5'd25: v = 32'd20;
			5'd26: v = 32'd10;
			5'd27: v = 32'd5;
			5'd28: v = 32'd3;
			5'd29: v = 32'd1;
			5'd30: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: sv/q2e_ctrl.sv
`timescale 1ns / 1ps
// sequencer for the quaternion to euler bins block
// depends on q2e_pkg

module q2e_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  q2e_pkg::sts_t   sts,
	output q2e_pkg::cmd_t   cmd
);

	q2e_pkg::state_t state_q, state_d;
	logic [q2e_pkg::CNT_W-1:0] count_q, count_d;
	logic [1:0] sel_q, sel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= q2e_pkg::ST_IDLE;
			count_q <= '0;
			sel_q   <= q2e_pkg::SEL_ROLL;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			sel_q   <= sel_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		sel_d    = sel_q;
		s_tready = 1'b0;
		cmd      = '0;
		cmd.sel  = sel_q;
		cmd.mul_idx = count_q[3:0];
		cmd.c_idx   = count_q[4:0];
		unique case (state_q)
			q2e_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					count_d  = '0;
					sel_d    = q2e_pkg::SEL_ROLL;
					state_d  = sts.in_orient ? q2e_pkg::ST_MUL : q2e_pkg::ST_DONE;
				end
			end
			q2e_pkg::ST_MUL: begin
				cmd.mul_en = (count_q < q2e_pkg::CNT_W'(q2e_pkg::MUL_STEPS));
				count_d    = count_q + 1'b1;
				if (count_q == q2e_pkg::CNT_W'(q2e_pkg::MUL_STEPS))
					state_d = q2e_pkg::ST_SQMUL;
			end
			q2e_pkg::ST_SQMUL: begin
				cmd.sq_mul = 1'b1;
				state_d    = q2e_pkg::ST_SQINIT;
			end
			q2e_pkg::ST_SQINIT: begin
				cmd.sq_init = 1'b1;
				count_d     = '0;
				state_d     = q2e_pkg::ST_SQRT;
			end
			q2e_pkg::ST_SQRT: begin
				cmd.sq_step = 1'b1;
				count_d     = count_q + 1'b1;
				if (count_q == q2e_pkg::CNT_W'(q2e_pkg::SQRT_STEPS - 1))
					state_d = q2e_pkg::ST_CINIT;
			end
			q2e_pkg::ST_CINIT: begin
				cmd.c_init = 1'b1;
				count_d    = '0;
				state_d    = q2e_pkg::ST_CITER;
			end
			q2e_pkg::ST_CITER: begin
				if (sts.y_zero || count_q == q2e_pkg::CNT_W'(q2e_pkg::ANGLE_ITERATIONS)
						|| count_q == q2e_pkg::CNT_W'(32)) begin
					state_d = q2e_pkg::ST_BIN;
				end else begin
					cmd.c_step = 1'b1;
					count_d    = count_q + 1'b1;
				end
			end
			q2e_pkg::ST_BIN: begin
				cmd.bin_en = 1'b1;
				if (sel_q == q2e_pkg::SEL_PITCH) begin
					state_d = q2e_pkg::ST_DONE;
				end else begin
					sel_d   = sel_q + 1'b1;
					state_d = q2e_pkg::ST_CINIT;
				end
			end
			q2e_pkg::ST_DONE: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = q2e_pkg::ST_IDLE;
				end
			end
			default: state_d = q2e_pkg::ST_IDLE;
		endcase
	end

endmodule

FILE: sv/q2e_datapath.sv
`timescale 1ns / 1ps
// datapath: shared multiplier, square root, shared cordic, binning, state and output register
// depends on q2e_pkg

module q2e_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [2:0]            in_kind,
	input  logic [71:0]           in_data,
	input  q2e_pkg::cmd_t         cmd,
	output q2e_pkg::sts_t         sts,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [23:0]           out_data
);

	localparam int CW  = q2e_pkg::CW;
	localparam int AW  = q2e_pkg::ANG_W;
	localparam int QW  = q2e_pkg::QW;
	localparam logic signed [CW-1:0] ONE_PROD = CW'(1) <<< (2 * q2e_pkg::QUAT_FRAC_BITS);
	localparam logic signed [CW-1:0] S_LIM    = CW'(1) <<< q2e_pkg::WORK_FRAC;
	localparam logic signed [AW-1:0] QUARTER  = AW'(1) <<< 30;
	localparam logic signed [AW-1:0] HALF     = AW'(1) <<< 31;
	localparam logic [q2e_pkg::SQ_W-1:0] SQ_ONE = q2e_pkg::SQ_W'(1) << (2 * q2e_pkg::WORK_FRAC);

	// latched item
	logic [2:0] kind_q, pose_q;
	logic       side_q;
	logic signed [QW-1:0] w_q, x_q, y_q, z_q;

	// products
	logic signed [QW-1:0] ma, mb;
	logic signed [q2e_pkg::PROD_W-1:0] prod_s1;
	logic [3:0] pidx_s1;
	logic       pv_s1;
	logic signed [q2e_pkg::ACC_W-1:0] acc_rn_q, acc_rd_q, acc_yn_q, acc_yd_q, acc_s_q;

	// sqrt
	logic signed [CW-1:0] s_w, s_cl, s_q;
	logic [q2e_pkg::SS_W-1:0] ss;
	logic [q2e_pkg::SQ_W-1:0] sq_q, n_q, res_q, bit_q, trial;

	// cordic
	logic signed [CW-1:0] rn_w, rd_w, yn_w, yd_w, ix, iy;
	logic signed [CW-1:0] cx_q, cy_q, xs, ys;
	logic signed [AW-1:0] ang_q, at;

	// binning
	logic signed [AW-1:0] u;
	logic [q2e_pkg::UB-1:0] uc;
	logic [q2e_pkg::BPROD_W-1:0] bprod, bsh;
	logic [q2e_pkg::BIN_W-1:0] bin_v;
	logic [q2e_pkg::BIN_W-1:0] roll_new_q, pitch_new_q, yaw_new_q;

	// stores and next values
	logic [q2e_pkg::BIN_W-1:0] roll_st_q, pitch_st_q, yaw_st_q, roll_d, pitch_d, yaw_d;
	logic worn_st_q, side_st_q, worn_d, side_d;
	logic [2:0] pose_st_q, pose_d;
	logic [1:0] vib_d;
	logic out_valid_q;
	logic [23:0] out_data_q;

	assign sts.in_orient = (in_kind == q2e_pkg::KIND_ORIENT);
	assign sts.y_zero    = (cy_q == '0);
	assign sts.out_free  = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign out_data      = out_data_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= in_kind;
			w_q    <= $signed(in_data[15:0]);
			x_q    <= $signed(in_data[31:16]);
			y_q    <= $signed(in_data[47:32]);
			z_q    <= $signed(in_data[63:48]);
			pose_q <= in_data[66:64];
			side_q <= in_data[67];
		end
	end

	// operand select for the shared multiplier
	always_comb begin
		case (cmd.mul_idx)
			4'd0: begin ma = w_q; mb = x_q; end
			4'd1: begin ma = y_q; mb = z_q; end
			4'd2: begin ma = x_q; mb = x_q; end
			4'd3: begin ma = y_q; mb = y_q; end
			4'd4: begin ma = w_q; mb = z_q; end
			4'd5: begin ma = x_q; mb = y_q; end
			4'd6: begin ma = z_q; mb = z_q; end
			4'd7: begin ma = w_q; mb = y_q; end
			default: begin ma = z_q; mb = x_q; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pv_s1 <= 1'b0;
		else
			pv_s1 <= cmd.mul_en;
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_s1 <= ma * mb;
			pidx_s1 <= cmd.mul_idx;
		end
		if (cmd.load) begin
			acc_rn_q <= '0;
			acc_rd_q <= '0;
			acc_yn_q <= '0;
			acc_yd_q <= '0;
			acc_s_q  <= '0;
		end else if (pv_s1) begin
			case (pidx_s1)
				4'd0, 4'd1: acc_rn_q <= acc_rn_q + q2e_pkg::ACC_W'(prod_s1);
				4'd2:       acc_rd_q <= acc_rd_q + q2e_pkg::ACC_W'(prod_s1);
				4'd3: begin
					acc_rd_q <= acc_rd_q + q2e_pkg::ACC_W'(prod_s1);
					acc_yd_q <= acc_yd_q + q2e_pkg::ACC_W'(prod_s1);
				end
				4'd4, 4'd5: acc_yn_q <= acc_yn_q + q2e_pkg::ACC_W'(prod_s1);
				4'd6:       acc_yd_q <= acc_yd_q + q2e_pkg::ACC_W'(prod_s1);
				4'd7:       acc_s_q  <= acc_s_q + q2e_pkg::ACC_W'(prod_s1);
				default:    acc_s_q  <= acc_s_q - q2e_pkg::ACC_W'(prod_s1);
			endcase
		end
	end

	// rescale to 30 fraction bits: doubled sums, then exact left shift
	assign rn_w = (CW'(acc_rn_q) <<< 1) <<< q2e_pkg::TO_WORK_SHIFT;
	assign yn_w = (CW'(acc_yn_q) <<< 1) <<< q2e_pkg::TO_WORK_SHIFT;
	assign rd_w = (ONE_PROD - (CW'(acc_rd_q) <<< 1)) <<< q2e_pkg::TO_WORK_SHIFT;
	assign yd_w = (ONE_PROD - (CW'(acc_yd_q) <<< 1)) <<< q2e_pkg::TO_WORK_SHIFT;
	assign s_w  = (CW'(acc_s_q) <<< 1) <<< q2e_pkg::TO_WORK_SHIFT;

	always_comb begin
		if (s_w > S_LIM)
			s_cl = S_LIM;
		else if (s_w < -S_LIM)
			s_cl = -S_LIM;
		else
			s_cl = s_w;
		ss = (s_cl < 0) ? q2e_pkg::SS_W'(-s_cl) : q2e_pkg::SS_W'(s_cl);
	end

	assign trial = res_q + bit_q;

	always_ff @(posedge clk) begin
		if (cmd.sq_mul) begin
			s_q  <= s_cl;
			sq_q <= q2e_pkg::SQ_W'(ss) * q2e_pkg::SQ_W'(ss);
		end
		if (cmd.sq_init) begin
			n_q   <= SQ_ONE - sq_q;
			res_q <= '0;
			bit_q <= SQ_ONE;
		end else if (cmd.sq_step) begin
			if (n_q >= trial) begin
				n_q   <= n_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	// cordic operand select
	always_comb begin
		case (cmd.sel)
			q2e_pkg::SEL_ROLL: begin iy = rn_w; ix = rd_w; end
			q2e_pkg::SEL_YAW:  begin iy = yn_w; ix = yd_w; end
			default: begin
				iy = s_q;
				ix = CW'(res_q[q2e_pkg::SS_W-1:0]);
			end
		endcase
	end

	assign xs = cx_q >>> cmd.c_idx;
	assign ys = cy_q >>> cmd.c_idx;
	assign at = AW'(q2e_pkg::atan_turn(cmd.c_idx));

	always_ff @(posedge clk) begin
		if (cmd.c_init) begin
			// axis cases end with y forced to zero so the loop stops at once
			if (iy == '0) begin
				cx_q  <= ix;
				cy_q  <= '0;
				ang_q <= (ix < 0) ? HALF : '0;
			end else if (ix == '0) begin
				cx_q  <= ix;
				cy_q  <= '0;
				ang_q <= (iy > 0) ? QUARTER : -QUARTER;
			end else if (ix < 0) begin
				if (iy > 0) begin
					cx_q  <= iy;
					cy_q  <= -ix;
					ang_q <= QUARTER;
				end else begin
					cx_q  <= -iy;
					cy_q  <= ix;
					ang_q <= -QUARTER;
				end
			end else begin
				cx_q  <= ix;
				cy_q  <= iy;
				ang_q <= '0;
			end
		end else if (cmd.c_step) begin
			if (cy_q > 0) begin
				cx_q  <= cx_q + ys;
				cy_q  <= cy_q - xs;
				ang_q <= ang_q + at;
			end else begin
				cx_q  <= cx_q - ys;
				cy_q  <= cy_q + xs;
				ang_q <= ang_q - at;
			end
		end
	end

	// angle to bin: bias, clamp, scale, saturate
	always_comb begin
		u = ang_q + ((cmd.sel == q2e_pkg::SEL_PITCH) ? QUARTER : HALF);
		if (u < 0)
			uc = '0;
		else if (cmd.sel == q2e_pkg::SEL_PITCH && u > HALF)
			uc = q2e_pkg::UB'(HALF);
		else if (u > (AW'(1) <<< 32))
			uc = q2e_pkg::UB'(AW'(1) <<< 32);
		else
			uc = q2e_pkg::UB'(u);
		bprod = q2e_pkg::BPROD_W'(uc) * q2e_pkg::BPROD_W'(q2e_pkg::BIN_COUNT);
		bsh   = (cmd.sel == q2e_pkg::SEL_PITCH) ? (bprod >> 31) : (bprod >> 32);
		if (bsh > q2e_pkg::BPROD_W'(q2e_pkg::BIN_COUNT))
			bin_v = q2e_pkg::BIN_W'(q2e_pkg::BIN_COUNT);
		else
			bin_v = bsh[q2e_pkg::BIN_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.bin_en) begin
			case (cmd.sel)
				q2e_pkg::SEL_ROLL: roll_new_q  <= bin_v;
				q2e_pkg::SEL_YAW:  yaw_new_q   <= bin_v;
				default:           pitch_new_q <= bin_v;
			endcase
		end
	end

	// event effect on the stored state
	always_comb begin
		roll_d  = roll_st_q;
		pitch_d = pitch_st_q;
		yaw_d   = yaw_st_q;
		worn_d  = worn_st_q;
		side_d  = side_st_q;
		pose_d  = pose_st_q;
		vib_d   = q2e_pkg::VIB_NONE;
		case (kind_q)
			q2e_pkg::KIND_ORIENT: begin
				roll_d  = roll_new_q;
				pitch_d = pitch_new_q;
				yaw_d   = yaw_new_q;
			end
			q2e_pkg::KIND_POSE: begin
				pose_d = pose_q;
				if (pose_q == q2e_pkg::POSE_FIST) begin
					vib_d = q2e_pkg::VIB_SHORT;
				end else if (pose_q == q2e_pkg::POSE_WAVE_IN) begin
					roll_d  = '0;
					pitch_d = '0;
					yaw_d   = '0;
					vib_d   = q2e_pkg::VIB_LONG;
				end
			end
			q2e_pkg::KIND_UNPAIR: begin
				roll_d  = '0;
				pitch_d = '0;
				yaw_d   = '0;
				worn_d  = 1'b0;
			end
			q2e_pkg::KIND_ARM_ON: begin
				worn_d = 1'b1;
				side_d = side_q;
			end
			q2e_pkg::KIND_ARM_OFF: worn_d = 1'b0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_st_q   <= '0;
			pitch_st_q  <= '0;
			yaw_st_q    <= '0;
			worn_st_q   <= 1'b0;
			side_st_q   <= 1'b0;
			pose_st_q   <= q2e_pkg::POSE_UNKNOWN;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				roll_st_q   <= roll_d;
				pitch_st_q  <= pitch_d;
				yaw_st_q    <= yaw_d;
				worn_st_q   <= worn_d;
				side_st_q   <= side_d;
				pose_st_q   <= pose_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit)
			out_data_q <= {2'b00, vib_d, pose_d, side_d, worn_d, yaw_d, pitch_d, roll_d};
	end

endmodule

FILE: sv/quaternion_to_euler_bins.sv
`timescale 1ns / 1ps
// top level of the quaternion to euler bins block
// depends on q2e_pkg, q2e_ctrl and q2e_datapath
//
// usage
// - input stream s_*: one armband event per transfer, kind in s_tuser, quaternion,
//   pose and arm side in s_tdata
// - output stream m_*: exactly one result per event with the current roll, pitch and
//   yaw bins, worn flag, arm side, latched pose and the vibrate request
// - orientation events: nine products through one shared 16x16 multiplier,
//   one squaring, a bit-per-cycle square root, then one shared cordic unit
//   runs roll, yaw and pitch in turn (up to 16 rotations each, fewer when y hits zero)
// - one event is in work at a time; s_tready is high whenever the sequencer is idle,
//   so the next event is taken while a finished result still waits in the output register
// - when the receiver stalls, the result holds in the output register and the sequencer
//   waits at its last step until the register frees up
// - reset clears the bins, worn flag and side, sets the pose to unknown and empties
//   the output register

module quaternion_to_euler_bins (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // quat_w, quat_x, quat_y, quat_z, pose_in, arm_side_in, pad
	input  logic [2:0]  s_tuser,  // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // roll_bin, pitch_bin, yaw_bin, worn_flag, left_arm,
	                              // pose_out, vibrate_req, pad
);

	q2e_pkg::cmd_t cmd;  // sequencer commands
	q2e_pkg::sts_t sts;  // datapath status

	q2e_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	q2e_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_kind   (s_tuser),
		.in_data   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

FILE: tb/sv/q2e_checker.sv
`timescale 1ns / 1ps
// result checker for quaternion_to_euler_bins: models the event decoder state and
// compares each output transfer with the predicted bins and flags; depends on q2e_pkg

module q2e_checker
	import q2e_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [71:0] s_tdata,
	input  logic [2:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [4:0] roll;
		logic [4:0] pitch;
		logic [4:0] yaw;
		logic       worn;
		logic       left;
		logic [2:0] pose;
		logic [1:0] vib;
	} pose_result_t;

	localparam longint QUARTER = 64'sd1 << 30;
	localparam longint HALF    = 64'sd1 << 31;

	pose_result_t expected_results[$];
	logic [4:0] roll_q, pitch_q, yaw_q;
	logic       worn_q, left_q;
	logic [2:0] pose_q;

	function automatic longint fshift(longint v, int s);
		if (v >= 0)
			return v >>> s;
		return -((-(v + 1)) >>> s) - 1;
	endfunction

	function automatic longint rescale(longint v);
		if (2 * QUAT_FRAC_BITS >= WORK_FRAC)
			return fshift(v, 2 * QUAT_FRAC_BITS - WORK_FRAC);
		return v * (64'sd1 <<< (WORK_FRAC - 2 * QUAT_FRAC_BITS));
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// vectoring atan2 in 2^-32 turn units
	function automatic longint angle_of(longint y, longint x);
		longint ang, t, xs, ys;
		ang = 0;
		if (y == 0)
			return (x < 0) ? HALF : 0;
		if (x == 0)
			return (y > 0) ? QUARTER : -QUARTER;
		if (x < 0) begin
			if (y > 0) begin
				t = x; x = y; y = -t; ang = QUARTER;
			end else begin
				t = x; x = -y; y = t; ang = -QUARTER;
			end
		end
		for (int i = 0; i < ANGLE_ITERATIONS && i < 32; i++) begin
			if (y == 0)
				break;
			xs = fshift(x, i);
			ys = fshift(y, i);
			if (y > 0) begin
				x = x + ys; y = y - xs; ang = ang + longint'(atan_turn(5'(i)));
			end else begin
				x = x - ys; y = y + xs; ang = ang - longint'(atan_turn(5'(i)));
			end
		end
		return ang;
	endfunction

	function automatic logic [4:0] quantize(longint ang, longint bias, int bits);
		longint u, top;
		longint unsigned b;
		u = ang + bias;
		top = 64'sd1 <<< bits;
		if (u < 0) u = 0;
		if (u > top) u = top;
		b = (longint'(u) * BIN_COUNT) >> bits;
		if (b > BIN_COUNT) b = BIN_COUNT;
		return b[4:0];
	endfunction

	function automatic void apply_event(logic [2:0] kind, logic [71:0] d,
			output pose_result_t r);
		longint w, x, y, z, one, rn, rd, yn, yd, s, lim;
		longint unsigned ss, c;
		logic [1:0] vib;
		vib = VIB_NONE;
		w = longint'($signed(d[15:0]));
		x = longint'($signed(d[31:16]));
		y = longint'($signed(d[47:32]));
		z = longint'($signed(d[63:48]));
		case (kind)
			KIND_ORIENT: begin
				one = 64'sd1 <<< (2 * QUAT_FRAC_BITS);
				rn = rescale(2 * (w * x + y * z));
				rd = rescale(one - 2 * (x * x + y * y));
				yn = rescale(2 * (w * z + x * y));
				yd = rescale(one - 2 * (y * y + z * z));
				s  = rescale(2 * (w * y - z * x));
				lim = 64'sd1 <<< WORK_FRAC;
				if (s > lim) s = lim;
				if (s < -lim) s = -lim;
				ss = (s < 0) ? -s : s;
				c = int_sqrt((64'd1 << (2 * WORK_FRAC)) - ss * ss);
				roll_q  = quantize(angle_of(rn, rd), HALF, 32);
				yaw_q   = quantize(angle_of(yn, yd), HALF, 32);
				pitch_q = quantize(angle_of(s, longint'(c)), QUARTER, 31);
			end
			KIND_POSE: begin
				pose_q = d[66:64];
				if (pose_q == POSE_FIST) begin
					vib = VIB_SHORT;
				end else if (pose_q == POSE_WAVE_IN) begin
					roll_q = 0; pitch_q = 0; yaw_q = 0;
					vib = VIB_LONG;
				end
			end
			KIND_UNPAIR: begin
				roll_q = 0; pitch_q = 0; yaw_q = 0;
				worn_q = 1'b0;
			end
			KIND_ARM_ON: begin
				worn_q = 1'b1;
				left_q = d[67];
			end
			KIND_ARM_OFF: worn_q = 1'b0;
			default: ;
		endcase
		r = '{roll_q, pitch_q, yaw_q, worn_q, left_q, pose_q, vib};
	endfunction

	pose_result_t got, want, nxt;

	assign pending = expected_results.size();

	// unpack the output transfer, lowest field first
	assign got = '{m_tdata[4:0], m_tdata[9:5], m_tdata[14:10], m_tdata[15], m_tdata[16],
		m_tdata[19:17], m_tdata[21:20]};

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_q <= 0; pitch_q <= 0; yaw_q <= 0;
			worn_q <= 0; left_q <= 0; pose_q <= POSE_UNKNOWN;
			fail_count <= 0;
			expected_results.delete();
		end else begin
			// the output side first: a result cannot come out in the cycle its event goes in
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result transfer %h", m_tdata);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						if (fail_count < 10)
							$display("mismatch: roll %0d/%0d pitch %0d/%0d yaw %0d/%0d worn %b/%b left %b/%b pose %0d/%0d vib %0d/%0d (exp/got)",
								want.roll, got.roll, want.pitch, got.pitch, want.yaw, got.yaw,
								want.worn, got.worn, want.left, got.left, want.pose, got.pose,
								want.vib, got.vib);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				apply_event(s_tuser, s_tdata, nxt);
				expected_results.push_back(nxt);
			end
		end
	end

endmodule

FILE: tb/sv/quaternion_to_euler_bins_tb.sv
`timescale 1ns / 1ps
// testbench top for quaternion_to_euler_bins: drives armband events with random gaps
// and output stalls; depends on q2e_pkg, q2e_checker and the block itself

module quaternion_to_euler_bins_tb;
	import q2e_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;    // quat_w, quat_x, quat_y, quat_z, pose_in, arm_side_in
	logic [2:0]  s_tuser = '0;    // kind
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;         // roll, pitch, yaw, worn, left, pose, vibrate
	int          fail_count, pending;
	bit          calm = 1'b0;     // no idling on either side while set

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	quaternion_to_euler_bins dut (.*);
	q2e_checker chk (.*);

	// receiver stalls about a third of the time except in calm stretches
	always @(negedge clk)
		m_tready <= calm || ($urandom_range(99) >= 33);

	// one event transfer, with a random gap first; valid stays up until the next gap
	task automatic send_event(logic [2:0] kind, logic [15:0] w, logic [15:0] x,
			logic [15:0] y, logic [15:0] z, logic [2:0] pose, logic side);
		while (!calm && $urandom_range(99) < 33) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {4'b0, side, pose, z, y, x, w};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [15:0] rand_comp();
		case ($urandom_range(9))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'(16'(int'($urandom)));   // full range, also non-unit values
			3: return 16'd0;
			default: return 16'($signed($urandom_range(32768)) - 16384);
		endcase
	endfunction

	// random unit quaternion, normalized with real arithmetic
	task automatic send_unit_quat();
		real a, b, c, d, n;
		a = $itor($signed($urandom_range(2000)) - 1000);
		b = $itor($signed($urandom_range(2000)) - 1000);
		c = $itor($signed($urandom_range(2000)) - 1000);
		d = $itor($signed($urandom_range(2000)) - 1000);
		n = $sqrt(a * a + b * b + c * c + d * d);
		if (n == 0.0) begin
			a = 1.0; n = 1.0;
		end
		send_event(KIND_ORIENT, 16'($rtoi(a / n * 16384.0)), 16'($rtoi(b / n * 16384.0)),
			16'($rtoi(c / n * 16384.0)), 16'($rtoi(d / n * 16384.0)),
			3'($urandom), 1'($urandom));
	endtask

	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int p;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: identity, axis turns, extremes, zero and non-unit vectors
		send_event(KIND_ORIENT, 16'sd16384, 0, 0, 0, 0, 0);
		send_event(KIND_ORIENT, 0, 16'sd16384, 0, 0, 0, 0);   // roll at half turn
		send_event(KIND_ORIENT, 0, 0, 16'sd16384, 0, 0, 0);
		send_event(KIND_ORIENT, 0, 0, 0, 16'sd16384, 0, 0);
		send_event(KIND_ORIENT, -16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384, 0, 0);
		send_event(KIND_ORIENT, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 0, 0);
		send_event(KIND_ORIENT, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 7, 1);
		send_event(KIND_ORIENT, 0, 0, 0, 0, 0, 0);
		send_event(KIND_ORIENT, 16'sd11585, 0, 16'sd11585, 0, 0, 0);   // pitch up
		send_event(KIND_ORIENT, 16'sd11585, 0, -16'sd11585, 0, 0, 0);  // pitch down
		send_event(KIND_ORIENT, 16'sd11585, 16'sd11585, 0, 0, 0, 0);
		send_event(KIND_ARM_ON, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 7, 1);
		send_event(KIND_POSE, 0, 0, 0, 0, POSE_FIST, 0);
		send_event(KIND_POSE, 0, 0, 0, 0, POSE_WAVE_IN, 0);
		for (int k = 0; k < 8; k++)
			send_event(KIND_POSE, 0, 0, 0, 0, 3'(k), 0);
		send_event(KIND_ARM_OFF, 0, 0, 0, 0, 0, 0);
		send_event(KIND_ARM_ON, 0, 0, 0, 0, 0, 0);
		send_event(KIND_UNPAIR, 0, 0, 0, 0, 0, 0);
		for (int k = 5; k < 8; k++)
			send_event(3'(k), 16'sd16384, 0, 0, 0, 1, 1);

		// hold off until every result has come back
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);

		for (int n = 0; n < 1100; n++) begin
			calm = (n >= 500 && n < 600);
			p = $urandom_range(99);
			if (p < 45)
				send_unit_quat();
			else if (p < 60)
				send_event(KIND_ORIENT, rand_comp(), rand_comp(), rand_comp(), rand_comp(),
					3'($urandom), 1'($urandom));
			else
				send_event(3'($urandom_range(p < 97 ? 4 : 7)), 16'($urandom),
					16'($urandom), 16'($urandom), 16'($urandom), 3'($urandom),
					1'($urandom));
		end

		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (120) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: sim.f
sv/q2e_pkg.sv
sv/q2e_ctrl.sv
sv/q2e_datapath.sv
sv/quaternion_to_euler_bins.sv
tb/sv/q2e_checker.sv
tb/sv/quaternion_to_euler_bins_tb.sv
